@@ rtl/hbg_pkg.sv @@
// shared types and constants for the hysteresis bargraph display block
// no dependencies; imported by hbg_ctrl, hbg_datapath and the top level
`default_nettype none

package hbg_pkg;

   // field widths fixed by the interface
   localparam int LEVEL_W  = 8;
   localparam int MODE_W   = 2;
   localparam int TIME_W   = 32;
   localparam int HYST_W   = 6;
   localparam int PERIOD_W = 16;
   localparam int LED_W    = 7;
   localparam int LIT_W    = 3;
   localparam int THR_W    = 7;
   localparam int SUM_W    = 9;
   localparam int CSR_IDX_W = 2;

   // register reset values
   localparam logic [HYST_W-1:0]   HYST_RESET    = 6'd2;
   localparam logic [PERIOD_W-1:0] SENSOR_RESET  = 16'd250;
   localparam logic [PERIOD_W-1:0] TIMEOUT_RESET = 16'd500;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HYST    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd2;

   // request kinds
   localparam logic ACT_LEVEL = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   // pump modes
   localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SENSOR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_UP   = 5'b00010,
      ST_DOWN = 5'b00100,
      ST_TICK = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step_up;
      logic step_down;
      logic tick;
      logic respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_tick;
      logic can_up;
      logic can_down;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/hbg_ctrl.sv @@
// controller state machine for the bargraph block
// depends on hbg_pkg for the state, command and status types
`default_nettype none

module hbg_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire hbg_pkg::status_type status,
   output hbg_pkg::cmd_type        cmd
);
   import hbg_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.req_tick ? ST_TICK : ST_UP;
            end
         end
         ST_UP: begin
            if (status.can_up) begin
               cmd.step_up = 1'b1;
            end else begin
               state_in = ST_DOWN;
            end
         end
         ST_DOWN: begin
            if (status.can_down) begin
               cmd.step_down = 1'b1;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/hbg_datapath.sv @@
// datapath: settings registers, bargraph count, blink timing, led and response registers
// depends on hbg_pkg for widths, codes and the command and status types
`default_nettype none

module hbg_datapath #(
   parameter int NUM_LEDS = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [hbg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hbg_pkg::PERIOD_W-1:0]  csr_wdata,
   input  wire logic                          req_action,
   input  wire logic [hbg_pkg::LEVEL_W-1:0]   req_level,
   input  wire logic [hbg_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [hbg_pkg::TIME_W-1:0]    req_now,
   input  wire hbg_pkg::cmd_type              cmd,
   output hbg_pkg::status_type                status,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [hbg_pkg::LED_W-1:0]          rsp_pattern,
   output logic                               rsp_written,
   output logic [hbg_pkg::LIT_W-1:0]          rsp_lit
);
   import hbg_pkg::*;

   localparam int CNT_W = $clog2(NUM_LEDS + 1);
   localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

   // settings
   logic [HYST_W-1:0]   hyst_ff;
   logic [PERIOD_W-1:0] sensor_period_ff;
   logic [PERIOD_W-1:0] timeout_period_ff;

   // captured request
   logic [LEVEL_W-1:0] level_ff;
   logic [TIME_W-1:0]  now_ff;

   // block state
   logic [CNT_W-1:0]  bar_count_ff, bar_count_in;
   logic [MODE_W-1:0] shown_mode_ff;
   logic [TIME_W-1:0] blink_start_ff;
   logic              blink_phase_ff;
   logic [LED_W-1:0]  led_ff, led_in;
   logic              written_ff;

   // response register
   logic             rsp_valid_ff;
   logic [LED_W-1:0] rsp_pattern_ff;
   logic             rsp_written_ff;
   logic [LIT_W-1:0] rsp_lit_ff;

   // threshold of led i+1, worked out at elaboration
   logic [THR_W-1:0] thr_tab [0:NUM_LEDS-1];
   for (genvar i = 0; i < NUM_LEDS; i++) begin : g_thr
      localparam int THR_VAL = (i * 100 + 50) / NUM_LEDS;
      assign thr_tab[i] = THR_W'(THR_VAL);
   end

   // settings writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff           <= HYST_RESET;
         sensor_period_ff  <= SENSOR_RESET;
         timeout_period_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HYST:    hyst_ff           <= csr_wdata[HYST_W-1:0];
            CSR_SENSOR:  sensor_period_ff  <= csr_wdata;
            CSR_TIMEOUT: timeout_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // threshold lookups for the step up and step down tests
   logic [CNT_W-1:0] count_m1;
   logic [IDX_W-1:0] up_idx, down_idx;
   logic             below_top, above_zero;
   logic [THR_W-1:0] up_thr, down_thr;
   logic [SUM_W-1:0] up_rhs, down_lhs;

   always_comb begin
      below_top  = (32'(bar_count_ff) < NUM_LEDS);
      above_zero = (bar_count_ff != '0);
      count_m1   = bar_count_ff - CNT_W'(1);
      up_idx     = below_top  ? bar_count_ff[IDX_W-1:0] : '0;
      down_idx   = above_zero ? count_m1[IDX_W-1:0]     : '0;
      up_thr     = thr_tab[up_idx];
      down_thr   = thr_tab[down_idx];
      up_rhs     = {2'b00, up_thr} + {3'b000, hyst_ff};
      down_lhs   = {1'b0, level_ff} + {3'b000, hyst_ff};
   end

   assign status.req_tick = (req_action == ACT_TICK);
   assign status.can_up   = below_top && ({1'b0, level_ff} >= up_rhs);
   assign status.can_down = above_zero && (down_lhs < {2'b00, down_thr});
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // led patterns for the bargraph and both fault displays
   logic [LED_W-1:0] bar_pat, all_pat, alt_pat;
   logic             new_phase;

   always_comb begin
      new_phase = !blink_phase_ff;
      bar_pat   = '0;
      all_pat   = '0;
      alt_pat   = '0;
      for (int i = 0; i < LED_W; i++) begin
         if (i < NUM_LEDS) begin
            bar_pat[i] = (32'(i) < 32'(bar_count_ff));
            all_pat[i] = new_phase;
            alt_pat[i] = ((i % 2) == 0) ? new_phase : !new_phase;
         end
      end
   end

   // blink timing with wrapping elapsed time
   logic [PERIOD_W-1:0] period;
   logic [TIME_W-1:0]   elapsed;
   logic                fault_mode, due;

   always_comb begin
      fault_mode = (shown_mode_ff == MODE_SENSOR) || (shown_mode_ff == MODE_TIMEOUT);
      period     = (shown_mode_ff == MODE_SENSOR) ? sensor_period_ff : timeout_period_ff;
      elapsed    = now_ff - blink_start_ff;
      due        = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period});
      led_in     = (shown_mode_ff == MODE_SENSOR) ? all_pat : alt_pat;
      bar_count_in = bar_count_ff;
      if (cmd.step_up) begin
         bar_count_in = bar_count_ff + CNT_W'(1);
      end else if (cmd.step_down) begin
         bar_count_in = count_m1;
      end
   end

   // request capture and display state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         level_ff <= req_level;
         now_ff   <= req_now;
      end
      if (reset) begin
         bar_count_ff   <= '0;
         shown_mode_ff  <= MODE_STOPPED;
         blink_start_ff <= '0;
         blink_phase_ff <= 1'b0;
         led_ff         <= '0;
         written_ff     <= 1'b0;
      end else begin
         bar_count_ff <= bar_count_in;
         if (cmd.load) begin
            written_ff <= 1'b0;
            if (req_action == ACT_LEVEL) begin
               shown_mode_ff <= req_mode;
            end
         end
         if (cmd.tick) begin
            if (fault_mode) begin
               if (due) begin
                  blink_start_ff <= now_ff;
                  blink_phase_ff <= new_phase;
                  led_ff         <= led_in;
                  written_ff     <= 1'b1;
               end
            end else begin
               blink_start_ff <= now_ff;
               blink_phase_ff <= 1'b0;
               led_ff         <= bar_pat;
               written_ff     <= 1'b1;
            end
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.respond) begin
         rsp_pattern_ff <= led_ff;
         rsp_written_ff <= written_ff;
         rsp_lit_ff     <= LIT_W'(bar_count_ff);
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_pattern = rsp_pattern_ff;
   assign rsp_written = rsp_written_ff;
   assign rsp_lit     = rsp_lit_ff;

endmodule

`default_nettype wire

@@ rtl/hysteresis_bargraph_with_fault_blink.sv @@
// top level of the hysteresis led bargraph with fault blinking
// depends on hbg_pkg, hbg_ctrl and hbg_datapath
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tuser: action; tdata: level, mode, time
//   rsp     | out       | rsp_tvalid/tready    | tuser: written; tdata: pattern, count
//   csr     | in        | csr_wr_en, no wait   | csr_index, csr_wdata
//
// a tick request passes through the tick and response states before the next accept;
// a level request steps the bargraph count up, then down, one step of the bargraph
// count per cycle through the threshold compare, then passes through the response state
// synchronous reset clears the count, mode, blink state and leds and reloads the
// default settings
// a request is taken while the previous response waits in the output register;
// the controller holds its response state while that register stays full
`default_nettype none

module hysteresis_bargraph_with_fault_blink #(
   parameter int NUM_LEDS = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // level_pct[7:0], pump_mode[9:8], now_ms[41:10], zero
   input  wire logic [0:0]  req_tuser,  // action[0]
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // led_pattern[6:0], lit_count[9:7], zero
   output logic [0:0]       rsp_tuser,  // pattern_written[0]
   // settings write port
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import hbg_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [LED_W-1:0] rsp_pattern;
   logic             rsp_written;
   logic [LIT_W-1:0] rsp_lit;

   hbg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hbg_datapath #(
      .NUM_LEDS (NUM_LEDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_action  (req_tuser[0]),
      .req_level   (req_tdata[7:0]),
      .req_mode    (req_tdata[9:8]),
      .req_now     (req_tdata[41:10]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_pattern (rsp_pattern),
      .rsp_written (rsp_written),
      .rsp_lit     (rsp_lit)
   );

   // response packing
   assign rsp_tdata = {6'b000000, rsp_lit, rsp_pattern};
   assign rsp_tuser = rsp_written;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for hysteresis_bargraph_with_fault_blink
// drives level and tick requests with random gaps and predicts every response
// needs hbg_pkg and the top level from rtl
`timescale 1ns / 1ps

module testbench;
   import hbg_pkg::*;

   localparam int NUM_LEDS     = 7;
   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 4;
   // settle time before settings change
   localparam int DRAIN_CYCLES = 2 * (NUM_LEDS + 4) + 4;
   localparam int PHASE_ITEMS  = 250;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // one predicted response
   typedef struct {
      logic [LED_W-1:0] led;
      logic             written;
      logic [LIT_W-1:0] lit;
   } display_type;

   // predicts the display and checks responses in order
   class display_scoreboard;
      logic [HYST_W-1:0]   hyst;
      logic [PERIOD_W-1:0] sensor_ms;
      logic [PERIOD_W-1:0] timeout_ms;
      int                  lit_leds;
      logic [MODE_W-1:0]   pump_mode;
      logic [TIME_W-1:0]   blink_start;
      bit                  blink_on;
      logic [LED_W-1:0]    led_reg;
      display_type         expected_displays[$];
      int                  mismatches;

      function new();
         hyst        = HYST_RESET;
         sensor_ms   = SENSOR_RESET;
         timeout_ms  = TIMEOUT_RESET;
         lit_leds    = 0;
         pump_mode   = MODE_STOPPED;
         blink_start = '0;
         blink_on    = 1'b0;
         led_reg     = '0;
         mismatches  = 0;
      endfunction

      // middle of the step of led k
      function int led_threshold(int k);
         return (k * 100 - 50) / NUM_LEDS;
      endfunction

      function logic [LED_W-1:0] bar_pattern(int n);
         logic [LED_W-1:0] p;
         p = '0;
         for (int i = 0; i < NUM_LEDS && i < LED_W; i++)
            if (i < n) p[i] = 1'b1;
         return p;
      endfunction

      function logic [LED_W-1:0] alternate_pattern(bit odd_leds);
         logic [LED_W-1:0] p;
         p = '0;
         for (int i = 0; i < NUM_LEDS && i < LED_W; i++)
            if (((i % 2) == 0) == odd_leds) p[i] = 1'b1;
         return p;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
         case (idx)
            CSR_HYST:    hyst       = value[HYST_W-1:0];
            CSR_SENSOR:  sensor_ms  = value;
            CSR_TIMEOUT: timeout_ms = value;
            default: ;
         endcase
      endfunction

      // work out the response of one accepted request
      function void note_request(logic action, logic [LEVEL_W-1:0] level,
                                 logic [MODE_W-1:0] mode, logic [TIME_W-1:0] now);
         display_type         d;
         logic [TIME_W-1:0]   elapsed;
         logic [PERIOD_W-1:0] period;
         d.written = 1'b0;
         if (action == ACT_LEVEL) begin
            pump_mode = mode;
            while (lit_leds < NUM_LEDS &&
                   int'(level) >= led_threshold(lit_leds + 1) + int'(hyst))
               lit_leds++;
            while (lit_leds > 0 && int'(level) < led_threshold(lit_leds) - int'(hyst))
               lit_leds--;
         end else if (pump_mode == MODE_SENSOR || pump_mode == MODE_TIMEOUT) begin
            period  = (pump_mode == MODE_SENSOR) ? sensor_ms : timeout_ms;
            elapsed = now - blink_start;
            if (elapsed >= {16'b0, period}) begin
               blink_start = now;
               blink_on    = !blink_on;
               led_reg     = (pump_mode == MODE_SENSOR) ?
                             (blink_on ? bar_pattern(NUM_LEDS) : '0) :
                             alternate_pattern(blink_on);
               d.written   = 1'b1;
            end
         end else begin
            led_reg     = bar_pattern(lit_leds);
            blink_start = now;
            blink_on    = 1'b0;
            d.written   = 1'b1;
         end
         d.led = led_reg;
         d.lit = lit_leds[LIT_W-1:0];
         expected_displays.push_back(d);
      endfunction

      function void check_response(logic [LED_W-1:0] led, logic written,
                                   logic [LIT_W-1:0] lit);
         display_type d;
         if (expected_displays.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: led %b written %b lit %0d", led, written, lit);
            return;
         end
         d = expected_displays.pop_front();
         if (led !== d.led || written !== d.written || lit !== d.lit) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected led %b written %b lit %0d, %s %b %s %b lit %0d",
                        d.led, d.written, d.lit, "got led", led, "written", written, lit);
         end
      endfunction

      function int pending();
         return expected_displays.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [47:0]          req_tdata;
   logic [0:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [15:0]          rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   display_scoreboard sb;
   bit                steady;
   int                requests_sent;
   logic [TIME_W-1:0] clock_ms;

   hysteresis_bargraph_with_fault_blink #(
      .NUM_LEDS (NUM_LEDS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // run limit
   initial begin
      #(10_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   // one request, waits a random gap first and returns at its accepting edge
   task automatic send_request(input logic action, input logic [LEVEL_W-1:0] level,
                               input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] now);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {6'b0, now, mode, level};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(action, level, mode, now);
      requests_sent++;
   endtask

   task automatic send_level(input logic [LEVEL_W-1:0] level, input logic [MODE_W-1:0] mode);
      send_request(ACT_LEVEL, level, mode, $urandom);
   endtask

   // tick after advancing the millisecond clock
   task automatic send_tick(input logic [TIME_W-1:0] delta);
      clock_ms = clock_ms + delta;
      send_request(ACT_TICK, LEVEL_W'($urandom_range(0, 255)), MODE_W'($urandom_range(0, 3)),
                   clock_ms);
   endtask

   // drop valid and let every response come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   // new settings, the spare index gets junk that must be ignored
   task automatic configure(input logic [15:0] hyst_word, input logic [15:0] sensor_word,
                            input logic [15:0] timeout_word);
      wait_idle();
      write_reg(CSR_HYST, hyst_word);
      write_reg(CSR_SENSOR, sensor_word);
      write_reg(CSR_TIMEOUT, timeout_word);
      write_reg(CSR_SPARE, 16'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   // level near a threshold edge, sometimes anywhere
   function automatic logic [LEVEL_W-1:0] pick_level();
      int k;
      int v;
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 255);
         1: v = $urandom_range(0, 110);
         default: begin
            k = $urandom_range(1, NUM_LEDS);
            v = sb.led_threshold(k) + ($urandom_range(0, 1) ? int'(sb.hyst) : -int'(sb.hyst))
                + int'($urandom_range(0, 4)) - 2;
         end
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[LEVEL_W-1:0];
   endfunction

   // time step around the blink period
   function automatic logic [TIME_W-1:0] pick_delta(input logic [PERIOD_W-1:0] period);
      case ($urandom_range(0, 9))
         0, 1, 2: return (period == 0) ? '0 : $urandom_range(0, int'(period) - 1);
         3, 4:    return {16'b0, period};
         5, 6:    return {16'b0, period} + $urandom_range(1, 3);
         7:       return '0;
         8:       return $urandom;
         default: return $urandom_range(0, 2 * int'(period) + 2);
      endcase
   endfunction

   // random part: mostly fault and bargraph episodes, some noise
   task automatic run_random(input int count);
      int                target;
      int                n;
      logic [MODE_W-1:0] mode;
      target = requests_sent + count;
      while (requests_sent < target) begin
         steady = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               mode = $urandom_range(0, 1) ? MODE_SENSOR : MODE_TIMEOUT;
               send_level(pick_level(), mode);
               n = $urandom_range(2, 8);
               repeat (n)
                  send_tick(pick_delta(mode == MODE_SENSOR ? sb.sensor_ms : sb.timeout_ms));
            end
            4, 5, 6: begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  send_level(pick_level(), $urandom_range(0, 1) ? MODE_STOPPED : MODE_RUNNING);
                  send_tick(pick_delta(16'd100));
               end
            end
            7, 8: begin
               n = $urandom_range(2, 6);
               repeat (n) send_level(pick_level(), MODE_W'($urandom_range(0, 3)));
               send_tick(pick_delta(sb.sensor_ms));
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n)
                  send_request(1'($urandom_range(0, 1)), LEVEL_W'($urandom_range(0, 255)),
                               MODE_W'($urandom_range(0, 3)), $urandom);
            end
         endcase
      end
   endtask

   // response side with random stalls
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_tvalid);
         sb.check_response(rsp_tdata[6:0], rsp_tuser[0], rsp_tdata[9:7]);
      end
   end

   // main sequence
   initial begin
      sb            = new();
      steady        = 1'b0;
      requests_sent = 0;
      clock_ms      = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extremes, every mode, wrapping time
      send_request(ACT_TICK, 8'd0, MODE_STOPPED, 32'd0);
      send_level(8'd255, MODE_RUNNING);
      send_request(ACT_TICK, 8'd0, MODE_STOPPED, 32'hFFFF_FFFF);
      send_level(8'd0, MODE_STOPPED);
      send_request(ACT_TICK, 8'hFF, MODE_RUNNING, 32'd5);
      send_level(8'd52, MODE_STOPPED);
      send_level(8'd51, MODE_STOPPED);
      send_level(8'd47, MODE_STOPPED);
      send_request(ACT_TICK, 8'd0, MODE_STOPPED, 32'd6);
      send_level(8'd100, MODE_SENSOR);
      clock_ms = 32'hFFFF_FF80;
      send_tick(32'd0);
      send_tick(32'd249);
      send_tick(32'd1);
      send_tick(32'd250);
      send_level(8'd30, MODE_TIMEOUT);
      send_tick(32'd499);
      send_tick(32'd1);
      send_tick(32'd500);
      send_tick(32'd0);
      send_level(8'd200, MODE_RUNNING);
      send_tick(32'd1);
      send_level(8'd93, MODE_STOPPED);
      send_tick(32'd1);

      // settings phases, extremes first
      for (int phase_no = 0; phase_no < 7; phase_no++) begin
         case (phase_no)
            0: configure(16'd0, 16'd1, 16'd1);
            1: configure(16'd50, 16'hFFFF, 16'hFFFF);
            2: configure(16'hFFFF, 16'd0, 16'd0);
            3: configure(16'd2, 16'd250, 16'd500);
            4: configure(16'($urandom_range(0, 50)), 16'($urandom_range(1, 40)),
                         16'($urandom_range(1, 40)));
            5: configure(16'($urandom), 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 65535)));
            default: configure(16'($urandom_range(0, 63)), 16'($urandom_range(0, 1000)),
                               16'($urandom_range(0, 1000)));
         endcase
         run_random(PHASE_ITEMS);
      end

      steady = 1'b0;
      wait_idle();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
